FILE: design/gbp_pkg.sv
// Shared types and operation codes for the gshare branch predictor.
// No dependencies; the top level and the testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package gbp_pkg;

	// Operation codes carried in the command beat
	localparam logic [2:0] OP_LOOKUP      = 3'd0;
	localparam logic [2:0] OP_UNCOND      = 3'd1;
	localparam logic [2:0] OP_BTB_UPDATE  = 3'd2;
	localparam logic [2:0] OP_RESOLVE     = 3'd3;
	localparam logic [2:0] OP_RESOLVE_SQ  = 3'd4;
	localparam logic [2:0] OP_SQUASH      = 3'd5;

	// Fixed field widths of the command and result beats
	localparam int THREAD_FIELD_W = 2;
	localparam int SNAP_W         = 12;

	typedef struct packed {
		logic [2:0]                opcode;
		logic [THREAD_FIELD_W-1:0] thread;
		logic [63:0]               inst_addr;
		logic                      taken;
		logic [SNAP_W-1:0]         saved_history;
	} gbp_cmd_t;

	typedef struct packed {
		logic              prediction;
		logic [SNAP_W-1:0] history_snapshot;
	} gbp_result_t;

endpackage

`default_nettype wire

FILE: design/gbp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gbp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read; a same-address read returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: design/gbp_clear.sv
// Post-reset clearing sequencer for the pattern counter table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gbp_clear #(
	parameter int DEPTH = 4096,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	output logic               clearing,
	output logic [AW-1:0]      addr
);

	logic [AW:0] clr_q;

	assign clearing = (clr_q < (AW+1)'(DEPTH));
	assign addr     = clr_q[AW-1:0];

	// Advance one entry per cycle until the whole table is written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + (AW+1)'(1);
		end
	end

endmodule

`default_nettype wire

FILE: design/gbp_history.sv
// Per-thread global history registers with a write-through read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gbp_history #(
	parameter int HISTORY_BITS = 12,
	parameter int THREADS      = 4,
	parameter int TID_W        = (THREADS > 1) ? $clog2(THREADS) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    upd_en,
	input  wire logic [TID_W-1:0]        upd_thread,
	input  wire logic [HISTORY_BITS-1:0] upd_value,
	input  wire logic [TID_W-1:0]        rd_thread,
	output logic      [HISTORY_BITS-1:0] rd_value
);

	logic [HISTORY_BITS-1:0] hist_q [THREADS];

	// Forward an update landing this cycle so the next beat sees it
	always_comb begin
		if (upd_en && (upd_thread == rd_thread)) begin
			rd_value = upd_value;
		end else if (32'(rd_thread) < 32'(THREADS)) begin
			rd_value = hist_q[rd_thread];
		end else begin
			rd_value = '0;
		end
	end

	// Hold each thread's history; load on update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREADS; i++) begin
				hist_q[i] <= '0;
			end
		end else if (upd_en) begin
			hist_q[upd_thread] <= upd_value;
		end
	end

endmodule

`default_nettype wire

FILE: design/gshare_branch_predictor_top.sv
// Top level of the gshare branch predictor: decode, table access, result register.
// Depends on gbp_pkg, gbp_ram, gbp_clear and gbp_history.
`timescale 1ns / 1ps
`default_nettype none

// One command beat is taken per cycle while busy is low. Its result beat shows
// on result with done high for one cycle; the receiver cannot stall it. The
// path from command to result runs through the registered read port of the
// counter table (read issued at acceptance, counter used and written back in
// the next cycle) and the result register.
// History and counter updates of a beat are forwarded to the next beat, so
// back-to-back commands on the same thread or table entry need no gaps.
// After reset, busy stays high while the counter table is cleared,
// one entry per cycle.
module gshare_branch_predictor_top
	import gbp_pkg::*;
#(
	parameter int HISTORY_BITS  = 12,
	parameter int TABLE_ENTRIES = 4096,
	parameter int COUNTER_BITS  = 2,
	parameter int THREADS       = 4,
	parameter int PC_SHIFT      = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire gbp_cmd_t    cmd,
	output logic             busy,
	output logic             done,
	output gbp_result_t      result
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int TID_W = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam int HB    = HISTORY_BITS;
	localparam int CB    = COUNTER_BITS;

	logic              clearing;
	logic [IDX_W-1:0]  clr_addr;
	logic              acc;
	logic              thread_ok;
	logic [TID_W-1:0]  tid;
	logic [HB-1:0]     hist_cur;
	logic [HB-1:0]     saved_h;
	logic [HB-1:0]     pc_part;
	logic [IDX_W-1:0]  raddr;
	logic [CB-1:0]     rdata;

	// Stage 1 registers
	logic              valid_s1;
	logic [2:0]        op_s1;
	logic              ok_s1;
	logic [TID_W-1:0]  tid_s1;
	logic              taken_s1;
	logic [HB-1:0]     saved_s1;
	logic [HB-1:0]     hist_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              byp_s1;
	logic [CB-1:0]     byp_data_s1;

	// Stage 1 logic
	logic [CB-1:0]     ctr;
	logic [CB-1:0]     ctr_next;
	logic              wr_en;
	logic              hist_en;
	logic [HB-1:0]     hist_new;
	logic              pred;
	logic [SNAP_W-1:0] snap;

	// Table write port mux
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [CB-1:0]     ram_wdata;

	gbp_clear #(
		.DEPTH (TABLE_ENTRIES),
		.AW    (IDX_W)
	) u_clear (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (clearing),
		.addr     (clr_addr)
	);

	gbp_history #(
		.HISTORY_BITS (HB),
		.THREADS      (THREADS),
		.TID_W        (TID_W)
	) u_history (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd_en     (hist_en),
		.upd_thread (tid_s1),
		.upd_value  (hist_new),
		.rd_thread  (tid),
		.rd_value   (hist_cur)
	);

	gbp_ram #(
		.WIDTH (CB),
		.DEPTH (TABLE_ENTRIES),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign busy = clearing;
	assign acc  = start && !busy;

	// Decode the incoming beat and form the table read address
	assign thread_ok = ({{(32-THREAD_FIELD_W){1'b0}}, cmd.thread} < 32'(THREADS));
	assign tid       = TID_W'(cmd.thread);
	assign saved_h   = HB'(cmd.saved_history);
	assign pc_part   = HB'(cmd.inst_addr >> PC_SHIFT);

	always_comb begin
		if (cmd.opcode == OP_RESOLVE) begin
			raddr = IDX_W'(pc_part ^ saved_h);
		end else begin
			raddr = IDX_W'(pc_part ^ hist_cur);
		end
	end

	// Capture the beat into stage 1, with a bypass for a same-cycle write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1       <= cmd.opcode;
			ok_s1       <= thread_ok;
			tid_s1      <= tid;
			taken_s1    <= cmd.taken;
			saved_s1    <= saved_h;
			hist_s1     <= hist_cur;
			idx_s1      <= raddr;
			byp_s1      <= wr_en && (idx_s1 == raddr);
			byp_data_s1 <= ctr_next;
		end
	end

	// Stage 1: pick the current counter and work out the operation
	assign ctr = byp_s1 ? byp_data_s1 : rdata;

	always_comb begin
		if (taken_s1) begin
			ctr_next = (ctr == '1) ? ctr : ctr + CB'(1);
		end else begin
			ctr_next = (ctr == '0) ? ctr : ctr - CB'(1);
		end
	end

	always_comb begin
		wr_en    = 1'b0;
		hist_en  = 1'b0;
		hist_new = hist_s1;
		pred     = 1'b0;
		snap     = '0;
		if (valid_s1 && ok_s1) begin
			case (op_s1)
				OP_LOOKUP: begin
					pred     = ctr[CB-1];
					snap     = SNAP_W'(hist_s1);
					hist_en  = 1'b1;
					hist_new = HB'({hist_s1, ctr[CB-1]});
				end
				OP_UNCOND: begin
					pred     = 1'b1;
					snap     = SNAP_W'(hist_s1);
					hist_en  = 1'b1;
					hist_new = HB'({hist_s1, 1'b1});
				end
				OP_BTB_UPDATE: begin
					hist_en  = 1'b1;
					hist_new = hist_s1 & ~HB'(1);
				end
				OP_RESOLVE: begin
					wr_en = 1'b1;
				end
				OP_RESOLVE_SQ: begin
					hist_en  = 1'b1;
					hist_new = HB'({saved_s1, taken_s1});
				end
				OP_SQUASH: begin
					hist_en  = 1'b1;
					hist_new = saved_s1;
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	// Table write: clearing pass first, then counter updates
	assign ram_we    = clearing || wr_en;
	assign ram_waddr = clearing ? clr_addr : idx_s1;
	assign ram_wdata = clearing ? '0 : ctr_next;

	// Result register and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result.prediction       <= pred;
			result.history_snapshot <= snap;
		end
	end

endmodule

`default_nettype wire

FILE: sim/gshare_branch_predictor_top_tb.sv
// Self-checking testbench for gshare_branch_predictor_top: directed and random command beats.
// Depends on gbp_pkg and the design; a scoreboard class predicts every result beat.
`timescale 1ns / 1ps

module gshare_branch_predictor_top_tb;
	import gbp_pkg::*;

	localparam int  HIST_W       = 12;
	localparam int  N_THREADS    = 4;
	localparam int  N_COUNTERS   = 4096;
	localparam int  ADDR_SHIFT   = 2;
	localparam logic [1:0] CTR_TOP  = 2'd3;
	localparam logic [1:0] CTR_HALF = 2'd1;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;
	localparam int  RANDOM_BEATS = 1950;
	localparam int  CALM_BEATS   = 600;
	localparam int  POOL_SIZE    = 24;
	localparam int  STALL_LIMIT  = 20000;
	localparam int  TAIL_CYCLES  = 6;

	// Predicts the result of each command and checks result beats in order
	class gshare_scoreboard;
		logic [HIST_W-1:0] thread_hist [N_THREADS];
		logic [1:0]        pattern_ctr [N_COUNTERS];
		gbp_result_t       expected_q [$];
		int                mismatches;
		int                checked;

		function new();
			foreach (thread_hist[i]) thread_hist[i] = '0;
			foreach (pattern_ctr[i]) pattern_ctr[i] = '0;
			mismatches = 0;
			checked = 0;
		endfunction

		function automatic logic [HIST_W-1:0] table_slot(logic [63:0] addr,
				logic [HIST_W-1:0] hist);
			return addr[ADDR_SHIFT +: HIST_W] ^ hist;
		endfunction

		// Apply one accepted command to the model state and queue its result
		function gbp_result_t note_command(gbp_cmd_t c);
			gbp_result_t       r;
			logic [HIST_W-1:0] hist;
			logic [HIST_W-1:0] idx;
			r = '0;
			if (c.thread < N_THREADS) begin
				hist = thread_hist[c.thread];
				case (c.opcode)
					OP_LOOKUP: begin
						idx = table_slot(c.inst_addr, hist);
						r.prediction = (pattern_ctr[idx] > CTR_HALF);
						r.history_snapshot = hist;
						thread_hist[c.thread] = {hist[HIST_W-2:0], r.prediction};
					end
					OP_UNCOND: begin
						r.prediction = 1'b1;
						r.history_snapshot = hist;
						thread_hist[c.thread] = {hist[HIST_W-2:0], 1'b1};
					end
					OP_BTB_UPDATE: begin
						thread_hist[c.thread] = {hist[HIST_W-1:1], 1'b0};
					end
					OP_RESOLVE: begin
						idx = table_slot(c.inst_addr, c.saved_history);
						if (c.taken && pattern_ctr[idx] != CTR_TOP)
							pattern_ctr[idx] = pattern_ctr[idx] + 2'd1;
						else if (!c.taken && pattern_ctr[idx] != 2'd0)
							pattern_ctr[idx] = pattern_ctr[idx] - 2'd1;
					end
					OP_RESOLVE_SQ: begin
						thread_hist[c.thread] = {c.saved_history[HIST_W-2:0], c.taken};
					end
					OP_SQUASH: begin
						thread_hist[c.thread] = c.saved_history;
					end
					default: begin
					end
				endcase
			end
			expected_q.push_back(r);
			return r;
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH at %0t ns: %s", $time, what);
			mismatches++;
		endtask

		// Compare one result beat against the oldest expectation
		task check_result(gbp_result_t got);
			gbp_result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result beat pred=%0b snap=%03h",
					got.prediction, got.history_snapshot));
			end else begin
				want = expected_q.pop_front();
				checked++;
				if (got.prediction !== want.prediction)
					report_mismatch($sformatf("prediction %0b, expected %0b",
						got.prediction, want.prediction));
				if (got.history_snapshot !== want.history_snapshot)
					report_mismatch($sformatf("history_snapshot %03h, expected %03h",
						got.history_snapshot, want.history_snapshot));
			end
		endtask
	endclass

	typedef struct packed {
		logic [1:0]        thread;
		logic [4:0]        slot;
		logic [HIST_W-1:0] snap;
		logic              pred;
	} branch_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	gbp_cmd_t    cmd = '0;
	logic        busy;
	logic        done;
	gbp_result_t result;

	gshare_scoreboard sb = new();
	branch_rec_t      in_flight [$];
	logic [63:0]      addr_pool [POOL_SIZE];
	int               idle_pct = 35;
	int               beats_sent = 0;
	int               stall_cycles = 0;

	gshare_branch_predictor_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always #6 clk = ~clk;

	// Check every result beat at the edge that ends its cycle
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_result(result);
	end

	// Stop the run if neither side moves a beat for too long
	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic gbp_cmd_t make_cmd(logic [2:0] op, logic [1:0] t, logic [63:0] a,
			logic tk, logic [HIST_W-1:0] sv);
		gbp_cmd_t c;
		c.opcode = op;
		c.thread = t;
		c.inst_addr = a;
		c.taken = tk;
		c.saved_history = sv;
		return c;
	endfunction

	function automatic logic [63:0] rand_addr();
		return {$urandom, $urandom};
	endfunction

	// Drive one command beat from a falling edge; return once it is accepted
	task send_beat(input gbp_cmd_t c, output gbp_result_t exp);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		cmd = c;
		do @(posedge clk); while (busy !== 1'b0);
		exp = sb.note_command(c);
		beats_sent++;
		@(negedge clk);
	endtask

	// Hold off new beats until every expected result has come back
	task drain_results();
		start = 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
	endtask

	// Drop the entry at index k and every younger entry of the same thread
	task drop_younger(int k);
		logic [1:0] t;
		t = in_flight[k].thread;
		for (int i = in_flight.size() - 1; i >= k; i--)
			if (in_flight[i].thread == t) in_flight.delete(i);
	endtask

	// Retire the oldest branch; on most mispredictions rebuild the history
	task resolve_oldest();
		branch_rec_t e;
		gbp_result_t exp;
		logic        tk;
		e = in_flight[0];
		tk = ($urandom_range(99) < ((e.slot % 3 != 0) ? 85 : 15));
		send_beat(make_cmd(OP_RESOLVE, e.thread, addr_pool[e.slot], tk, e.snap), exp);
		if (tk != e.pred && $urandom_range(99) < 80) begin
			send_beat(make_cmd(OP_RESOLVE_SQ, e.thread, rand_addr(), tk, e.snap), exp);
			drop_younger(0);
		end else begin
			in_flight.delete(0);
		end
	endtask

	// One random action: mostly branch streams, some squashes and noise
	task random_action();
		gbp_result_t exp;
		branch_rec_t e;
		int          pick;
		int          k;
		logic [1:0]  t;
		pick = $urandom_range(99);
		t = 2'($urandom_range(N_THREADS - 1));
		if (in_flight.size() > 10 || (pick >= 45 && pick < 73 && in_flight.size() != 0)) begin
			resolve_oldest();
		end else if (pick < 38) begin
			e.slot = 5'($urandom_range(POOL_SIZE - 1));
			send_beat(make_cmd(OP_LOOKUP, t, addr_pool[e.slot], 1'($urandom_range(1)),
				12'($urandom_range(4095))), exp);
			e.thread = t;
			e.snap = exp.history_snapshot;
			e.pred = exp.prediction;
			in_flight.push_back(e);
		end else if (pick < 45) begin
			send_beat(make_cmd(OP_UNCOND, t, rand_addr(), 1'($urandom_range(1)),
				12'($urandom_range(4095))), exp);
		end else if (pick < 80 && in_flight.size() != 0) begin
			k = $urandom_range(in_flight.size() - 1);
			e = in_flight[k];
			send_beat(make_cmd(OP_SQUASH, e.thread, rand_addr(), 1'($urandom_range(1)),
				e.snap), exp);
			drop_younger(k);
		end else if (pick < 85) begin
			send_beat(make_cmd(OP_BTB_UPDATE, t, rand_addr(), 1'($urandom_range(1)),
				12'($urandom_range(4095))), exp);
		end else begin
			send_beat(make_cmd(3'($urandom_range(7)), t, rand_addr(), 1'($urandom_range(1)),
				12'($urandom_range(4095))), exp);
		end
	endtask

	initial begin
		gbp_result_t exp;
		int          directed_beats;
		foreach (addr_pool[i]) addr_pool[i] = rand_addr();

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, every opcode, saturation at both ends
		send_beat(make_cmd(OP_LOOKUP, 2'd0, 64'd0, 1'b0, 12'h000), exp);
		send_beat(make_cmd(OP_UNCOND, 2'd1, '1, 1'b1, 12'hFFF), exp);
		send_beat(make_cmd(OP_LOOKUP, 2'd1, '1, 1'b0, 12'h000), exp);
		send_beat(make_cmd(OP_BTB_UPDATE, 2'd1, 64'd0, 1'b1, 12'hFFF), exp);
		send_beat(make_cmd(OP_SQUASH, 2'd2, 64'd0, 1'b0, 12'hFFF), exp);
		send_beat(make_cmd(OP_LOOKUP, 2'd2, '1, 1'b1, 12'h000), exp);
		send_beat(make_cmd(OP_RESOLVE_SQ, 2'd3, '1, 1'b1, 12'hFFF), exp);
		send_beat(make_cmd(OP_RESOLVE_SQ, 2'd3, 64'd0, 1'b0, 12'h000), exp);
		// Push one counter past its top, then predict from it
		repeat (4) send_beat(make_cmd(OP_RESOLVE, 2'd2, 64'd0, 1'b1, 12'h000), exp);
		send_beat(make_cmd(OP_LOOKUP, 2'd0, 64'd0, 1'b0, 12'h000), exp);
		// Walk it back down past zero
		repeat (4) send_beat(make_cmd(OP_RESOLVE, 2'd1, 64'd0, 1'b0, 12'h000), exp);
		send_beat(make_cmd(OP_SQUASH, 2'd0, '1, 1'b1, 12'h000), exp);
		send_beat(make_cmd(OP_LOOKUP, 2'd0, 64'd0, 1'b1, 12'hFFF), exp);
		// Unused opcodes change nothing
		send_beat(make_cmd(OP_SPARE_6, 2'd3, '1, 1'b1, 12'hFFF), exp);
		send_beat(make_cmd(OP_SPARE_7, 2'd0, 64'hFFFF_FFFF_FFFF_FFFC, 1'b0, 12'hA5A), exp);
		send_beat(make_cmd(OP_LOOKUP, 2'd3, 64'hFFFF_FFFF_FFFF_FFFC, 1'b1, 12'hFFF), exp);
		directed_beats = beats_sent;

		// Random: a calm stretch back to back, a full drain, then gaps
		idle_pct = 0;
		while (beats_sent < directed_beats + CALM_BEATS) random_action();
		drain_results();
		idle_pct = 35;
		while (beats_sent < directed_beats + RANDOM_BEATS) random_action();

		start = 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d command beats: directed extremes, trained branch streams with",
			beats_sent);
		$display("mispredict recovery, squashes and noise; %0d results checked, %0d mismatches",
			sb.checked, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/gbp_pkg.sv
design/gbp_ram.sv
design/gbp_clear.sv
design/gbp_history.sv
design/gshare_branch_predictor_top.sv
sim/gshare_branch_predictor_top_tb.sv
